// ----- design/mfac_pkg.sv -----
`default_nettype none
package mfac_pkg;

  // Q16.16 value width and saturation limits.
  localparam int unsigned QW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam logic signed [47:0] QMax = 48'sd2147483647;
  localparam logic signed [47:0] QMin = -48'sd2147483648;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ETA      = 3'd0,
    REG_MU       = 3'd1,
    REG_RHO      = 3'd2,
    REG_LAMBDA   = 3'd3,
    REG_FLOOR    = 3'd4,
    REG_CEILING  = 3'd5,
    REG_G1_INIT  = 3'd6,
    REG_G2_INIT  = 3'd7
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [30:0] EtaReset     = 31'd65536;
  localparam logic [30:0] MuReset      = 31'd65536;
  localparam logic [30:0] RhoReset     = 31'd65536;
  localparam logic [30:0] LambdaReset  = 31'd196608;
  localparam logic [30:0] FloorReset   = 31'd1;
  localparam logic [30:0] CeilingReset = 31'd3276800;
  localparam logic signed [31:0] G1InitReset = 32'sd32768;
  localparam logic signed [31:0] G2InitReset = -32'sd13107;

  // Reset values of the loop state.
  localparam logic signed [31:0] MeasReset  = 32'sd32768;
  localparam logic signed [31:0] DriveReset = 32'sd65536;

  // Clamp a wide signed value to the 32-bit range.
  function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > QMax) begin
      r = 32'sh7FFFFFFF;
    end else if (x < QMin) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Magnitude of a 32-bit signed value.
  function automatic logic [32:0] mag33(input logic signed [31:0] x);
    logic signed [32:0] w;
    w = 33'(x);
    return x[31] ? 33'(-w) : 33'(w);
  endfunction

endpackage
`default_nettype wire

// ----- design/mfac_in_if.sv -----
`default_nettype none
interface mfac_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink (input valid, input setpoint, input measured, output ready);
endinterface
`default_nettype wire

// ----- design/mfac_out_if.sv -----
`default_nettype none
interface mfac_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] drive_one;
  logic signed [31:0] drive_two;

  modport source (output valid, output drive_one, output drive_two, input ready);
  modport sink (input valid, input drive_one, input drive_two, output ready);
endinterface
`default_nettype wire

// ----- design/mfac_mul.sv -----
`default_nettype none
module mfac_mul (
  input  wire logic              clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [31:0]     r
);

  logic signed [63:0] prod;

  // Full product registered; result is floored by 2^16 and clamped.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  assign r = mfac_pkg::sat48(prod[63:16]);

endmodule
`default_nettype wire

// ----- design/mfac_div.sv -----
`default_nettype none
module mfac_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                   done,
  output logic signed [31:0]     quo
);

  logic        busy;
  logic        neg;
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [31:0] rem;
  logic [30:0] dsr;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [32:0] num_mag;

  // One restoring step per cycle; the dividend register collects quotient bits.
  assign rem_sh  = {rem, dvd[47]};
  assign diff    = rem_sh - {2'b00, dsr};
  assign num_mag = mfac_pkg::mag33(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[31];
      dvd <= {num_mag[31:0], 16'h0000};
      rem <= '0;
      cnt <= 6'd47;
      dsr <= (den < 32'sd1) ? 31'd1 : den[30:0];
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (!diff[32]) begin
        rem <= diff[31:0];
        dvd <= {dvd[46:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        dvd <= {dvd[46:0], 1'b0};
      end
    end
  end

  // Apply the sign and clamp the truncated quotient.
  always_comb begin
    if (neg) begin
      if (dvd > 48'h000080000000) begin
        quo = 32'sh80000000;
      end else begin
        quo = -$signed(dvd[31:0]);
      end
    end else begin
      if (dvd > 48'h00007FFFFFFF) begin
        quo = 32'sh7FFFFFFF;
      end else begin
        quo = $signed(dvd[31:0]);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/model_free_adaptive_two_input_controller.sv -----
// Two-input model-free adaptive controller, compact form, Q16.16 fixed point.
// Channel sample carries one request per plant step: setpoint and measured.
// Channel drive returns one result per request: the two new control values.
// Both channels use valid/ready; a transfer happens when both are high.
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// index 0 to 7 in the order eta, mu, rho, lambda, floor, ceiling, and the two
// gain restart values; write them only while the block is idle.
// drive.valid rises once both drives are updated: a single registered 32x32
// multiplier handles the thirteen products, and one radix-2 divider of 48
// steps handles the four divisions.
// sample.ready is high only in the idle state, so one request is in flight;
// a new request is taken only after the previous result has left on drive.
// The result is held on drive until drive.ready is high; the block then
// returns to idle and takes the next request.
// Synchronous reset restores the configuration defaults, the last measured
// output to 0.5, all four stored drives to 1.0 and both gain estimates to 0.
`default_nettype none
module model_free_adaptive_two_input_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mfac_in_if.sink                            sample,
  mfac_out_if.source                         drive,
  input  wire logic                          cfg_we,
  input  wire logic [mfac_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  typedef enum logic [24:0] {
    S_IDLE = 25'h0000001,
    S_E1   = 25'h0000002,
    S_E2   = 25'h0000004,
    S_E3   = 25'h0000008,
    S_E4   = 25'h0000010,
    S_E5   = 25'h0000020,
    S_E6   = 25'h0000040,
    S_E7   = 25'h0000080,
    S_E8   = 25'h0000100,
    S_E9   = 25'h0000200,
    S_D1   = 25'h0000400,
    S_D2   = 25'h0000800,
    S_GCHK = 25'h0001000,
    S_C1   = 25'h0002000,
    S_C2   = 25'h0004000,
    S_C3   = 25'h0008000,
    S_C4   = 25'h0010000,
    S_C5   = 25'h0020000,
    S_C6   = 25'h0040000,
    S_C7   = 25'h0080000,
    S_C8   = 25'h0100000,
    S_C9   = 25'h0200000,
    S_D3   = 25'h0400000,
    S_D4   = 25'h0800000,
    S_OUT  = 25'h1000000
  } state_t;

  state_t state;

  // Configuration.
  logic [30:0]        eta, mu, rho, lambda, floor_mag, ceil_mag;
  logic signed [31:0] g1_init, g2_init;

  // Loop state.
  logic signed [31:0] last_measured;
  logic signed [31:0] older_drive_one, newer_drive_one;
  logic signed [31:0] older_drive_two, newer_drive_two;
  logic signed [31:0] gain_one, gain_two;

  // Step working registers.
  logic signed [31:0] du1, du2, dy, err, e, den, tmp, num1, num2;
  logic signed [33:0] acc;

  // Shared units.
  logic signed [31:0] mul_a, mul_b, mres;
  logic               div_start, div_done;
  logic signed [31:0] div_num, dq;
  logic [32:0]        mag1, mag2;

  mfac_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .r   (mres)
  );

  mfac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (dq)
  );

  assign sample.ready    = (state == S_IDLE);
  assign drive.valid     = (state == S_OUT);
  assign drive.drive_one = newer_drive_one;
  assign drive.drive_two = newer_drive_two;

  assign mag1 = mfac_pkg::mag33(gain_one);
  assign mag2 = mfac_pkg::mag33(gain_two);

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_E1: begin mul_a = gain_one; mul_b = du1; end
      S_E2: begin mul_a = gain_two; mul_b = du2; end
      S_E3: begin mul_a = du1; mul_b = du1; end
      S_E4: begin mul_a = du2; mul_b = du2; end
      S_E5: begin mul_a = $signed({1'b0, eta}); mul_b = e; end
      S_E7: begin mul_a = tmp; mul_b = du1; end
      S_E8: begin mul_a = tmp; mul_b = du2; end
      S_C1: begin mul_a = gain_one; mul_b = gain_one; end
      S_C2: begin mul_a = gain_two; mul_b = gain_two; end
      S_C3: begin mul_a = $signed({1'b0, rho}); mul_b = gain_one; end
      S_C5: begin mul_a = tmp; mul_b = err; end
      S_C6: begin mul_a = $signed({1'b0, rho}); mul_b = gain_two; end
      S_C8: begin mul_a = tmp; mul_b = err; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Divider launch: the first numerator of a pair is already registered when
  // the sequencer starts it; the second follows on done.
  always_comb begin
    div_start = 1'b0;
    div_num   = num1;
    unique case (state)
      S_E9, S_C9: begin div_start = 1'b1; div_num = num1; end
      S_D1, S_D3: begin div_start = div_done; div_num = num2; end
      default: begin div_start = 1'b0; div_num = num1; end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      eta       <= mfac_pkg::EtaReset;
      mu        <= mfac_pkg::MuReset;
      rho       <= mfac_pkg::RhoReset;
      lambda    <= mfac_pkg::LambdaReset;
      floor_mag <= mfac_pkg::FloorReset;
      ceil_mag  <= mfac_pkg::CeilingReset;
      g1_init   <= mfac_pkg::G1InitReset;
      g2_init   <= mfac_pkg::G2InitReset;
    end else if (cfg_we) begin
      unique case (mfac_pkg::cfg_reg_t'(cfg_index))
        mfac_pkg::REG_ETA:     eta       <= cfg_data[30:0];
        mfac_pkg::REG_MU:      mu        <= cfg_data[30:0];
        mfac_pkg::REG_RHO:     rho       <= cfg_data[30:0];
        mfac_pkg::REG_LAMBDA:  lambda    <= cfg_data[30:0];
        mfac_pkg::REG_FLOOR:   floor_mag <= cfg_data[30:0];
        mfac_pkg::REG_CEILING: ceil_mag  <= cfg_data[30:0];
        mfac_pkg::REG_G1_INIT: g1_init   <= $signed(cfg_data);
        mfac_pkg::REG_G2_INIT: g2_init   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Sequencer and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      last_measured   <= mfac_pkg::MeasReset;
      older_drive_one <= mfac_pkg::DriveReset;
      newer_drive_one <= mfac_pkg::DriveReset;
      older_drive_two <= mfac_pkg::DriveReset;
      newer_drive_two <= mfac_pkg::DriveReset;
      gain_one        <= '0;
      gain_two        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            older_drive_one <= newer_drive_one;
            older_drive_two <= newer_drive_two;
            last_measured   <= sample.measured;
            state           <= S_E1;
          end
        end
        S_E1: state <= S_E2;
        S_E2: state <= S_E3;
        S_E3: state <= S_E4;
        S_E4: state <= S_E5;
        S_E5: state <= S_E6;
        S_E6: state <= S_E7;
        S_E7: state <= S_E8;
        S_E8: state <= S_E9;
        S_E9: state <= S_D1;
        S_D1: begin
          if (div_done) begin
            gain_one <= mfac_pkg::sat48(48'(gain_one) + 48'(dq));
            state    <= S_D2;
          end
        end
        S_D2: begin
          if (div_done) begin
            gain_two <= mfac_pkg::sat48(48'(gain_two) + 48'(dq));
            state    <= S_GCHK;
          end
        end
        S_GCHK: begin
          if (mag1 < 33'(floor_mag) || mag1 > 33'(ceil_mag)) begin
            gain_one <= g1_init;
          end
          if (mag2 < 33'(floor_mag) || mag2 > 33'(ceil_mag)) begin
            gain_two <= g2_init;
          end
          state <= S_C1;
        end
        S_C1: state <= S_C2;
        S_C2: state <= S_C3;
        S_C3: state <= S_C4;
        S_C4: state <= S_C5;
        S_C5: state <= S_C6;
        S_C6: state <= S_C7;
        S_C7: state <= S_C8;
        S_C8: state <= S_C9;
        S_C9: state <= S_D3;
        S_D3: begin
          if (div_done) begin
            newer_drive_one <= mfac_pkg::sat48(48'(newer_drive_one) + 48'(dq));
            state           <= S_D4;
          end
        end
        S_D4: begin
          if (div_done) begin
            newer_drive_two <= mfac_pkg::sat48(48'(newer_drive_two) + 48'(dq));
            state           <= S_OUT;
          end
        end
        S_OUT: begin
          if (drive.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers along the step.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        du1 <= mfac_pkg::sat48(48'(newer_drive_one) - 48'(older_drive_one));
        du2 <= mfac_pkg::sat48(48'(newer_drive_two) - 48'(older_drive_two));
        dy  <= mfac_pkg::sat48(48'(sample.measured) - 48'(last_measured));
        err <= mfac_pkg::sat48(48'(sample.setpoint) - 48'(sample.measured));
      end
      S_E2: acc <= 34'(dy) - 34'(mres);
      S_E3: e <= mfac_pkg::sat48(48'(acc) - 48'(mres));
      S_E4: acc <= 34'($signed({1'b0, mu})) + 34'(mres);
      S_E5: den <= mfac_pkg::sat48(48'(acc) + 48'(mres));
      S_E6: tmp <= mres;
      S_E8: num1 <= mres;
      S_E9: num2 <= mres;
      S_C2: acc <= 34'($signed({1'b0, lambda})) + 34'(mres);
      S_C3: den <= mfac_pkg::sat48(48'(acc) + 48'(mres));
      S_C4: tmp <= mres;
      S_C6: num1 <= mres;
      S_C7: tmp <= mres;
      S_C9: num2 <= mres;
      default: ;
    endcase
  end

endmodule
`default_nettype wire
